### design/bbt_pkg.sv
package bbt_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  localparam logic [20:0] CH_HASH   = 21'h23;
  localparam logic [20:0] CH_QUOTE  = 21'h22;
  localparam logic [20:0] CH_BSLASH = 21'h5c;
  localparam logic [20:0] CH_LPAREN = 21'h28;
  localparam logic [20:0] CH_RPAREN = 21'h29;
  localparam logic [20:0] CH_LSQ    = 21'h5b;
  localparam logic [20:0] CH_RSQ    = 21'h5d;
  localparam logic [20:0] CH_LCURLY = 21'h7b;
  localparam logic [20:0] CH_RCURLY = 21'h7d;

  typedef enum logic [1:0] {
    KIND_PAREN  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [20:0] ch;
    logic        line_end;
  } char_t;

  typedef struct packed {
    logic [6:0] open_count;
    logic       balanced;
    logic       overflow;
  } result_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t kind;
  } stack_op_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_next;
    kind_t            top;
    logic             full;
  } stack_status_t;

endpackage

### design/bbt_stack.sv
module bbt_stack (
  input  logic                  clk,
  input  logic                  rst,
  input  bbt_pkg::stack_op_t     op,
  output bbt_pkg::stack_status_t status
);

  bbt_pkg::kind_t mem [bbt_pkg::STACK_DEPTH];
  bbt_pkg::kind_t rdata;
  bbt_pkg::kind_t top_reg;
  bbt_pkg::kind_t top_cur;
  logic use_rdata;
  logic [bbt_pkg::CNT_W-1:0] count;
  logic [bbt_pkg::CNT_W-1:0] count_next;
  logic [bbt_pkg::IDX_W-1:0] rd_addr;

  // entry just below the top, so a pop has its new top in the cycle after it
  assign rd_addr = bbt_pkg::IDX_W'(count - bbt_pkg::CNT_W'(2));
  assign top_cur = use_rdata ? rdata : top_reg;

  always_comb begin
    count_next = count;
    if (op.push) begin
      count_next = count + bbt_pkg::CNT_W'(1);
    end else if (op.pop) begin
      count_next = count - bbt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[count[bbt_pkg::IDX_W-1:0]] <= op.kind;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      use_rdata <= 1'b0;
    end else begin
      count     <= count_next;
      use_rdata <= op.pop && !op.push;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      top_reg <= op.kind;
    end else if (!op.pop) begin
      top_reg <= top_cur;
    end
  end

  assign status.count      = count;
  assign status.count_next = count_next;
  assign status.top        = top_cur;
  assign status.full       = count == bbt_pkg::CNT_W'(bbt_pkg::STACK_DEPTH);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bbt_pkg::CNT_W'(bbt_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    op.push |-> !status.full)
    else $error("push onto a full stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    op.pop |-> count != '0)
    else $error("pop from an empty stack");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    op.push |=> top_cur == $past(op.kind))
    else $error("top does not follow pushed kind");

endmodule

### design/bracket_balance_tracker.sv
// Bracket balance tracker: takes one character per transaction and returns one result per
// character, in the cycle after it is taken, at a sustained rate of one character per clock;
// char_stall rises only while a result is held by result_stall. Expected closers live in a
// STACK_DEPTH x 2 synchronous memory that is read every cycle at the entry under the top,
// so a pop has its new top ready for the next character with no bubble. The memory needs no
// clearing pass after reset. Comment, string and escape modes end with each line.
module bracket_balance_tracker (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  bbt_pkg::char_t   char_data,
  output logic             result_valid,
  input  logic             result_stall,
  output bbt_pkg::result_t result
);

  logic accept;
  logic in_comment, in_string, escape_pending;
  logic in_comment_next, in_string_next, escape_pending_next;
  logic overflow_next;
  bbt_pkg::kind_t open_kind, close_kind;
  bbt_pkg::stack_op_t op;
  bbt_pkg::stack_status_t status;

  assign char_stall = result_valid && result_stall;
  assign accept     = char_valid && !char_stall;

  always_comb begin
    case (char_data.ch)
      bbt_pkg::CH_LPAREN: open_kind = bbt_pkg::KIND_PAREN;
      bbt_pkg::CH_LSQ:    open_kind = bbt_pkg::KIND_SQUARE;
      bbt_pkg::CH_LCURLY: open_kind = bbt_pkg::KIND_CURLY;
      default:            open_kind = bbt_pkg::KIND_NONE;
    endcase
    case (char_data.ch)
      bbt_pkg::CH_RPAREN: close_kind = bbt_pkg::KIND_PAREN;
      bbt_pkg::CH_RSQ:    close_kind = bbt_pkg::KIND_SQUARE;
      bbt_pkg::CH_RCURLY: close_kind = bbt_pkg::KIND_CURLY;
      default:            close_kind = bbt_pkg::KIND_NONE;
    endcase
  end

  always_comb begin
    in_comment_next     = in_comment;
    in_string_next      = in_string;
    escape_pending_next = escape_pending;
    overflow_next       = 1'b0;
    op.push             = 1'b0;
    op.pop              = 1'b0;
    op.kind             = open_kind;
    if (accept) begin
      if (in_comment) begin
        // rest of line ignored
      end else if (in_string) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (char_data.ch == bbt_pkg::CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (char_data.ch == bbt_pkg::CH_QUOTE) begin
          in_string_next = 1'b0;
        end
      end else if (char_data.ch == bbt_pkg::CH_HASH) begin
        in_comment_next = 1'b1;
      end else if (char_data.ch == bbt_pkg::CH_QUOTE) begin
        in_string_next      = 1'b1;
        escape_pending_next = 1'b0;
      end else if (open_kind != bbt_pkg::KIND_NONE) begin
        if (status.full) begin
          overflow_next = 1'b1;
        end else begin
          op.push = 1'b1;
        end
      end else if (close_kind != bbt_pkg::KIND_NONE) begin
        op.pop = (status.count != '0) && (status.top == close_kind);
      end
      if (char_data.line_end) begin
        in_comment_next     = 1'b0;
        in_string_next      = 1'b0;
        escape_pending_next = 1'b0;
      end
    end
  end

  bbt_stack u_stack (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment     <= 1'b0;
      in_string      <= 1'b0;
      escape_pending <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      in_comment     <= in_comment_next;
      in_string      <= in_string_next;
      escape_pending <= escape_pending_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.open_count <= 7'(status.count_next);
      result.balanced   <= status.count_next == '0;
      result.overflow   <= overflow_next;
    end
  end

endmodule
